@@ rtl/hws_pkg.sv @@
// Shared types, constants and state codes for the weighted Hessian size block.
`timescale 1ns / 1ps
package hws_pkg;

  localparam int unsigned MAX_COMPONENTS_DEF = 6;
  localparam int unsigned NUM_WEIGHTS        = 6;
  localparam int unsigned NUM_ENTRIES        = 9;
  localparam int unsigned ENTRY_W            = 32;
  localparam int unsigned SIZE_W             = 32;
  localparam int unsigned WEIGHT_W           = 16;
  localparam int unsigned WEIGHT_FRAC        = 8;
  localparam int unsigned SQUARE_W           = 2 * ENTRY_W;
  localparam int unsigned SUMSQ_W            = SQUARE_W + 2;
  localparam int unsigned ROOT_W             = SUMSQ_W / 2;
  localparam int unsigned REM_W              = ROOT_W + 3;
  localparam int unsigned TOTAL_W            = 48;
  localparam int unsigned TERM_W             = ROOT_W + WEIGHT_W - WEIGHT_FRAC;
  localparam int unsigned MUL_A_W            = ROOT_W;
  localparam int unsigned MUL_B_W            = ENTRY_W;
  localparam int unsigned PROD_W             = MUL_A_W + MUL_B_W;
  localparam int unsigned ENT_IDX_W          = $clog2(NUM_ENTRIES);
  localparam int unsigned WIDX_W             = $clog2(NUM_WEIGHTS);
  localparam int unsigned ROOT_CNT_W         = $clog2(ROOT_W + 1);
  localparam int unsigned CFG_IDX_W          = 3;
  localparam int unsigned CFG_DATA_W         = 32;

  localparam logic [SIZE_W-1:0]   MIN_SIZE_RST = SIZE_W'(6554);
  localparam logic [SIZE_W-1:0]   MAX_SIZE_RST = SIZE_W'(65536);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST   = WEIGHT_W'(256);
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = {TOTAL_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_SIZE = 3'd0,
    REG_MAX_SIZE = 3'd1,
    REG_WEIGHT_0 = 3'd2,
    REG_WEIGHT_1 = 3'd3,
    REG_WEIGHT_2 = 3'd4,
    REG_WEIGHT_3 = 3'd5,
    REG_WEIGHT_4 = 3'd6,
    REG_WEIGHT_5 = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SQ_DRAIN,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_WEIGH,
    ST_ACCUM,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              valid;
    logic [PROD_W-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [SUMSQ_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

endpackage

@@ rtl/hws_if.sv @@
// Valid/ready channel interfaces for Hessian items and vertex sizes.
`timescale 1ns / 1ps
interface hws_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [hws_pkg::ENTRY_W-1:0]  h_xx;
  logic signed [hws_pkg::ENTRY_W-1:0]  h_xy;
  logic signed [hws_pkg::ENTRY_W-1:0]  h_xz;
  logic signed [hws_pkg::ENTRY_W-1:0]  h_yx;
  logic signed [hws_pkg::ENTRY_W-1:0]  h_yy;
  logic signed [hws_pkg::ENTRY_W-1:0]  h_yz;
  logic signed [hws_pkg::ENTRY_W-1:0]  h_zx;
  logic signed [hws_pkg::ENTRY_W-1:0]  h_zy;
  logic signed [hws_pkg::ENTRY_W-1:0]  h_zz;
  logic                                last_component;

  modport source (output valid, h_xx, h_xy, h_xz, h_yx, h_yy, h_yz, h_zx, h_zy, h_zz,
                  last_component, input ready);
  modport sink (input valid, h_xx, h_xy, h_xz, h_yx, h_yy, h_yz, h_zx, h_zy, h_zz,
                last_component, output ready);
endinterface

interface hws_out_if;
  logic                         valid;
  logic                         ready;
  logic [hws_pkg::SIZE_W-1:0]   vertex_size;
  logic                         saturated;

  modport source (output valid, vertex_size, saturated, input ready);
  modport sink (input valid, vertex_size, saturated, output ready);
endinterface

@@ rtl/hws_mul.sv @@
// Shared registered multiplier used for the entry squares and the weighting.
`timescale 1ns / 1ps
module hws_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  hws_pkg::mul_req_t req,
  output hws_pkg::mul_rsp_t rsp
);
  import hws_pkg::*;

  logic              valid_r;
  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      prod_r <= PROD_W'(req.a) * PROD_W'(req.b);
    end
  end

  assign rsp.valid = valid_r;
  assign rsp.p     = prod_r;

endmodule

@@ rtl/hws_sqrt.sv @@
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module hws_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  hws_pkg::sqrt_req_t req,
  output hws_pkg::sqrt_rsp_t rsp
);
  import hws_pkg::*;

  logic [SUMSQ_W-1:0]    rad_r;
  logic [ROOT_W:0]       rem_r;
  logic [ROOT_W-1:0]     root_r;
  logic [ROOT_CNT_W-1:0] cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;
  logic [REM_W-1:0] rem_left;

  // Bring down the next two radicand bits and try the candidate 4q+1.
  assign rem_sh   = {rem_r, rad_r[SUMSQ_W-1 -: 2]};
  assign trial    = REM_W'({root_r, 2'b01});
  assign fits     = (rem_sh >= trial);
  assign rem_left = fits ? (rem_sh - trial) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= ROOT_CNT_W'(ROOT_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != ROOT_CNT_W'(1));
      done_r <= (cnt_r == ROOT_CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad_r  <= req.radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SUMSQ_W-3:0], 2'b00};
      rem_r  <= rem_left[ROOT_W:0];
      root_r <= {root_r[ROOT_W-2:0], fits};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

@@ rtl/hessian_weighted_size.sv @@
// Top level: sequencer, registers and datapath of the weighted Hessian size block.
//
//   channel  | dir | handshake              | contents
//   in_ch    | in  | valid/ready transfer   | nine Q16.16 Hessian entries, last_component
//   out_ch   | out | valid/ready transfer   | vertex_size (Q16.16), saturated
//   cfg_*    | in  | write enable, no ready | min_size, max_size, weight_0..weight_5
//
// The block takes no new item until the last one is through: nine issues of the
// shared multiplier for the squares, the bit-serial square root, then the
// weighting multiply, the accumulation and the finishing step.
// An item beyond the component limit goes straight from acceptance to the finishing step.
// Reset is synchronous and active low and is ready for an item in the next cycle.
// A held result waits in the output register while the next item is worked on;
// only a last-component item stalls in its finishing step until that register is free.
`timescale 1ns / 1ps
module hessian_weighted_size #(
  parameter int unsigned MAX_COMPONENTS = hws_pkg::MAX_COMPONENTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  hws_in_if.sink                           in_ch,
  hws_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [hws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hws_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hws_pkg::*;

  localparam int unsigned COMP_W = $clog2(MAX_COMPONENTS + 1);

  // Configuration registers
  logic [SIZE_W-1:0]   min_size_r;
  logic [SIZE_W-1:0]   max_size_r;
  logic [WEIGHT_W-1:0] weight_r [NUM_WEIGHTS];

  // Item and accumulation state
  state_t               state_r, state_nxt;
  logic [ENTRY_W-1:0]   ent_r [NUM_ENTRIES];
  logic                 last_r;
  logic [ENT_IDX_W-1:0] k_r;
  logic [SUMSQ_W-1:0]   sumsq_r;
  logic [TOTAL_W-1:0]   total_r;
  logic [COMP_W-1:0]    comp_r;
  logic                 ovf_r;

  // Output register
  logic                 out_valid_r;
  logic [SIZE_W-1:0]    out_size_r;
  logic                 out_sat_r;

  mul_req_t  mul_req;
  mul_rsp_t  mul_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  logic                 accept;
  logic                 in_range;
  logic                 out_free;
  logic                 emit;
  logic [ENTRY_W-1:0]   ent_sel;
  logic [ENTRY_W-1:0]   mag;
  logic [TERM_W-1:0]    term;
  logic [TOTAL_W:0]     sum_wide;
  logic [TOTAL_W-1:0]   diff;
  logic [SIZE_W-1:0]    size_sel;

  hws_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  hws_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_range = (comp_r < COMP_W'(MAX_COMPONENTS));
  assign out_free = !out_valid_r || out_ch.ready;

  // Magnitude of the selected entry; the most negative value maps onto 2^31.
  assign ent_sel = ent_r[k_r];
  assign mag     = ent_sel[ENTRY_W-1] ? (~ent_sel + 1'b1) : ent_sel;

  assign term     = mul_rsp.p[WEIGHT_FRAC +: TERM_W];
  assign sum_wide = (TOTAL_W + 1)'(total_r) + (TOTAL_W + 1)'(term);

  assign diff     = (total_r < TOTAL_W'(max_size_r)) ? (TOTAL_W'(max_size_r) - total_r) : '0;
  assign size_sel = (diff[SIZE_W-1:0] < min_size_r) ? min_size_r : diff[SIZE_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_range ? ST_SQUARE : ST_FINISH;
        end
      end
      ST_SQUARE: begin
        if (k_r == ENT_IDX_W'(NUM_ENTRIES - 1)) begin
          state_nxt = ST_SQ_DRAIN;
        end
      end
      ST_SQ_DRAIN:  state_nxt = ST_ROOT_GO;
      ST_ROOT_GO:   state_nxt = ST_ROOT_WAIT;
      ST_ROOT_WAIT: begin
        if (sqrt_rsp.done) begin
          state_nxt = ST_WEIGH;
        end
      end
      ST_WEIGH:     state_nxt = ST_ACCUM;
      ST_ACCUM:     state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (!last_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready       = 1'b0;
    mul_req.valid     = 1'b0;
    mul_req.a         = MUL_A_W'(mag);
    mul_req.b         = mag;
    sqrt_req.start    = 1'b0;
    sqrt_req.radicand = sumsq_r;
    emit              = 1'b0;
    unique case (state_r)
      ST_IDLE:    in_ch.ready = 1'b1;
      ST_SQUARE:  mul_req.valid = 1'b1;
      ST_ROOT_GO: sqrt_req.start = 1'b1;
      ST_WEIGH: begin
        mul_req.valid = 1'b1;
        mul_req.a     = sqrt_rsp.root;
        mul_req.b     = MUL_B_W'(weight_r[WIDX_W'(comp_r)]);
      end
      ST_FINISH:  emit = last_r && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_size_r <= MIN_SIZE_RST;
      max_size_r <= MAX_SIZE_RST;
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        weight_r[i] <= WEIGHT_RST;
      end
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_SIZE: min_size_r  <= cfg_data[SIZE_W-1:0];
        REG_MAX_SIZE: max_size_r  <= cfg_data[SIZE_W-1:0];
        REG_WEIGHT_0: weight_r[0] <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_1: weight_r[1] <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_2: weight_r[2] <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_3: weight_r[3] <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_4: weight_r[4] <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_5: weight_r[5] <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      comp_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && !in_range) begin
        ovf_r <= 1'b1;
      end
      if (state_r == ST_ACCUM) begin
        comp_r <= comp_r + 1'b1;
        if (sum_wide[TOTAL_W]) begin
          total_r <= TOTAL_MAX;
          ovf_r   <= 1'b1;
        end else begin
          total_r <= sum_wide[TOTAL_W-1:0];
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        total_r     <= '0;
        comp_r      <= '0;
        ovf_r       <= 1'b0;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent_r[0] <= in_ch.h_xx;
      ent_r[1] <= in_ch.h_xy;
      ent_r[2] <= in_ch.h_xz;
      ent_r[3] <= in_ch.h_yx;
      ent_r[4] <= in_ch.h_yy;
      ent_r[5] <= in_ch.h_yz;
      ent_r[6] <= in_ch.h_zx;
      ent_r[7] <= in_ch.h_zy;
      ent_r[8] <= in_ch.h_zz;
      last_r   <= in_ch.last_component;
      k_r      <= '0;
      sumsq_r  <= '0;
    end else begin
      if (state_r == ST_SQUARE) begin
        k_r <= k_r + 1'b1;
      end
      // Squares arrive from the multiplier register in the cycle after issue, so the drain step takes the last one.
      if (mul_rsp.valid && (state_r == ST_SQUARE || state_r == ST_SQ_DRAIN)) begin
        sumsq_r <= sumsq_r + SUMSQ_W'(mul_rsp.p[SQUARE_W-1:0]);
      end
    end
    if (emit) begin
      out_size_r <= size_sel;
      out_sat_r  <= ovf_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.vertex_size = out_size_r;
  assign out_ch.saturated   = out_sat_r;

endmodule
